@@ rtl/core/hti_pkg.sv @@
// Shared types and constants for the Hermite tension/bias interpolator.
package hti_pkg;

    // Default widths of the sample and position fields.
    localparam int SAMPLE_BITS_DEF   = 16;
    localparam int POSITION_BITS_DEF = 16;

    // Tension and bias registers are signed Q1.14 in a 16-bit word.
    localparam int REG_BITS = 16;
    localparam int ONE_Q14  = 16384;

    // A coefficient of the form 1.0 +/- register needs one bit more than the register.
    localparam int COEF_W = REG_BITS + 1;

    // Register stages from input acceptance to the output register.
    localparam int NUM_STAGES = 7;

    // Configuration register indexes.
    localparam int CFG_INDEX_BITS = 1;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_TENSION = 1'b0,
        REG_BIAS    = 1'b1
    } cfg_reg_t;

    // Tangent weights held in the form the datapath multiplies by.
    typedef struct packed {
        logic signed [COEF_W-1:0] bias_plus;     // 1.0 + bias
        logic signed [COEF_W-1:0] bias_minus;    // 1.0 - bias
        logic signed [COEF_W-1:0] tension_minus; // 1.0 - tension
    } coef_t;

    // Per-stage load enables shared by all datapath slices.
    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
    } ctrl_t;

endpackage

@@ rtl/core/hti_pipe_ctrl.sv @@
// Valid tracking and per-stage load enables; empty stages let later items move up.
module hti_pipe_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    output hti_pkg::ctrl_t ctrl
);

    localparam int LAST = hti_pkg::NUM_STAGES - 1;

    logic [hti_pkg::NUM_STAGES-1:0] valid_reg;
    logic [hti_pkg::NUM_STAGES-1:0] valid_next;
    logic [hti_pkg::NUM_STAGES-1:0] load;

    // A stage loads when it is empty or its contents move on this cycle.
    always_comb
    begin
        load[LAST] = !valid_reg[LAST] || out_ready;
        for (int k = LAST - 1; k >= 0; k--)
        begin
            load[k] = !valid_reg[k] || load[k+1];
        end
    end

    // Valid bits follow the data through the stages.
    always_comb
    begin
        valid_next[0] = load[0] ? in_valid : valid_reg[0];
        for (int k = 1; k <= LAST; k++)
        begin
            valid_next[k] = load[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign ctrl.load = load;
    assign in_ready  = load[0];
    assign out_valid = valid_reg[LAST];

endmodule

@@ rtl/core/hti_tangent.sv @@
// Tangent slice: neighbouring differences, bias weighting, tension scaling.
// Stages one to four; the interval samples are carried alongside.
module hti_tangent
#(
    parameter int SAMPLE_BITS = hti_pkg::SAMPLE_BITS_DEF
)
(
    input  logic                       clk,
    input  hti_pkg::ctrl_t             ctrl,
    input  hti_pkg::coef_t             coef,
    input  logic signed [SAMPLE_BITS-1:0] sample_before,
    input  logic signed [SAMPLE_BITS-1:0] sample_start,
    input  logic signed [SAMPLE_BITS-1:0] sample_end,
    input  logic signed [SAMPLE_BITS-1:0] sample_after,
    output logic signed [SAMPLE_BITS-1:0] start_out,
    output logic signed [SAMPLE_BITS-1:0] end_out,
    output logic signed [SAMPLE_BITS+6:0] tan_start,
    output logic signed [SAMPLE_BITS+6:0] tan_end
);

    localparam int DIFF_W = SAMPLE_BITS + 1;
    localparam int PD_W   = DIFF_W + hti_pkg::COEF_W;
    localparam int SUM_W  = PD_W + 1;
    localparam int U_W    = SUM_W - 14;
    localparam int MP_W   = U_W + hti_pkg::COEF_W;
    localparam int M_W    = MP_W - 15;

    localparam logic signed [SUM_W-1:0] U_HALF = SUM_W'(2 ** 13);
    localparam logic signed [MP_W-1:0]  M_HALF = MP_W'(2 ** 14);

    // Stage one: differences.
    logic signed [DIFF_W-1:0]      d0_reg, d1_reg, d2_reg;
    logic signed [SAMPLE_BITS-1:0] s1_st1_reg, s2_st1_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.load[0])
        begin
            d0_reg     <= DIFF_W'(sample_start) - DIFF_W'(sample_before);
            d1_reg     <= DIFF_W'(sample_end) - DIFF_W'(sample_start);
            d2_reg     <= DIFF_W'(sample_after) - DIFF_W'(sample_end);
            s1_st1_reg <= sample_start;
            s2_st1_reg <= sample_end;
        end
    end

    // Stage two: bias weighted sum of the two differences around each end.
    logic signed [PD_W-1:0]        p00, p01, p10, p11;
    logic signed [SUM_W-1:0]       sum0_reg, sum1_reg;
    logic signed [SAMPLE_BITS-1:0] s1_st2_reg, s2_st2_reg;

    assign p00 = d0_reg * coef.bias_plus;
    assign p01 = d1_reg * coef.bias_minus;
    assign p10 = d1_reg * coef.bias_plus;
    assign p11 = d2_reg * coef.bias_minus;

    always_ff @(posedge clk)
    begin
        if (ctrl.load[1])
        begin
            sum0_reg   <= SUM_W'(p00) + SUM_W'(p01);
            sum1_reg   <= SUM_W'(p10) + SUM_W'(p11);
            s1_st2_reg <= s1_st1_reg;
            s2_st2_reg <= s2_st1_reg;
        end
    end

    // Stage three: round to Q0 and scale by the tension weight.
    logic signed [SUM_W-1:0]       u0_sum, u1_sum;
    logic signed [U_W-1:0]         u0, u1;
    logic signed [MP_W-1:0]        mp0_reg, mp1_reg;
    logic signed [SAMPLE_BITS-1:0] s1_st3_reg, s2_st3_reg;

    assign u0_sum = sum0_reg + U_HALF;
    assign u1_sum = sum1_reg + U_HALF;
    assign u0     = u0_sum[SUM_W-1:14];
    assign u1     = u1_sum[SUM_W-1:14];

    always_ff @(posedge clk)
    begin
        if (ctrl.load[2])
        begin
            mp0_reg    <= u0 * coef.tension_minus;
            mp1_reg    <= u1 * coef.tension_minus;
            s1_st3_reg <= s1_st2_reg;
            s2_st3_reg <= s2_st2_reg;
        end
    end

    // Stage four: drop the Q2.14 scale of the tension weight and halve the product.
    logic signed [MP_W-1:0]        m0_sum, m1_sum;
    logic signed [M_W-1:0]         m0_reg, m1_reg;
    logic signed [SAMPLE_BITS-1:0] s1_st4_reg, s2_st4_reg;

    assign m0_sum = mp0_reg + M_HALF;
    assign m1_sum = mp1_reg + M_HALF;

    always_ff @(posedge clk)
    begin
        if (ctrl.load[3])
        begin
            m0_reg     <= m0_sum[MP_W-1:15];
            m1_reg     <= m1_sum[MP_W-1:15];
            s1_st4_reg <= s1_st3_reg;
            s2_st4_reg <= s2_st3_reg;
        end
    end

    assign start_out = s1_st4_reg;
    assign end_out   = s2_st4_reg;
    assign tan_start = m0_reg;
    assign tan_end   = m1_reg;

endmodule

@@ rtl/core/hti_basis.sv @@
// Basis slice: powers of the position and the four Hermite weights.
// Stages one to four, aligned with the tangent slice.
module hti_basis
#(
    parameter int POSITION_BITS = hti_pkg::POSITION_BITS_DEF
)
(
    input  logic                         clk,
    input  hti_pkg::ctrl_t               ctrl,
    input  logic [POSITION_BITS-1:0]     position,
    output logic signed [POSITION_BITS+2:0] basis0,
    output logic signed [POSITION_BITS+2:0] basis1,
    output logic signed [POSITION_BITS+2:0] basis2,
    output logic signed [POSITION_BITS+2:0] basis3
);

    localparam int P   = POSITION_BITS;
    localparam int SQ_W = 2 * P;
    localparam int A_W = P + 3;

    localparam logic [SQ_W-1:0]       SQ_HALF = SQ_W'(1) << (P - 1);
    localparam logic signed [A_W-1:0] ONE_P   = A_W'(1) << P;

    // Stage one: square of the position.
    logic [P-1:0]    mu_st1_reg;
    logic [SQ_W-1:0] sq_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.load[0])
        begin
            mu_st1_reg <= position;
            sq_reg     <= position * position;
        end
    end

    // Stage two: round the square and form the cube.
    logic [SQ_W-1:0] sq_sum;
    logic [P-1:0]    mu2;
    logic [P-1:0]    mu2_reg;
    logic [P-1:0]    mu_st2_reg;
    logic [SQ_W-1:0] cube_reg;

    assign sq_sum = sq_reg + SQ_HALF;
    assign mu2    = sq_sum[SQ_W-1:P];

    always_ff @(posedge clk)
    begin
        if (ctrl.load[1])
        begin
            mu2_reg    <= mu2;
            mu_st2_reg <= mu_st1_reg;
            cube_reg   <= mu2 * mu_st1_reg;
        end
    end

    // Stage three: round the cube and build the weights.
    logic [SQ_W-1:0]       cube_sum;
    logic [P-1:0]          mu3;
    logic signed [A_W-1:0] mu_e, mu2_e, mu3_e;
    logic signed [A_W-1:0] a0_reg, a1_reg, a2_reg, a3_reg;

    assign cube_sum = cube_reg + SQ_HALF;
    assign mu3      = cube_sum[SQ_W-1:P];
    assign mu_e     = A_W'(mu_st2_reg);
    assign mu2_e    = A_W'(mu2_reg);
    assign mu3_e    = A_W'(mu3);

    always_ff @(posedge clk)
    begin
        if (ctrl.load[2])
        begin
            a0_reg <= mu3_e + mu3_e - mu2_e - mu2_e - mu2_e + ONE_P;
            a1_reg <= mu3_e - mu2_e - mu2_e + mu_e;
            a2_reg <= mu3_e - mu2_e;
            a3_reg <= mu2_e + mu2_e + mu2_e - mu3_e - mu3_e;
        end
    end

    // Stage four: hold the weights while the tangents are rounded.
    logic signed [A_W-1:0] b0_reg, b1_reg, b2_reg, b3_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.load[3])
        begin
            b0_reg <= a0_reg;
            b1_reg <= a1_reg;
            b2_reg <= a2_reg;
            b3_reg <= a3_reg;
        end
    end

    assign basis0 = b0_reg;
    assign basis1 = b1_reg;
    assign basis2 = b2_reg;
    assign basis3 = b3_reg;

endmodule

@@ rtl/core/hti_combine.sv @@
// Weighted sum of samples and tangents, rounding and saturation.
// Stages five to seven; stage seven is the output register.
module hti_combine
#(
    parameter int SAMPLE_BITS   = hti_pkg::SAMPLE_BITS_DEF,
    parameter int POSITION_BITS = hti_pkg::POSITION_BITS_DEF
)
(
    input  logic                            clk,
    input  hti_pkg::ctrl_t                  ctrl,
    input  logic signed [POSITION_BITS+2:0] basis0,
    input  logic signed [POSITION_BITS+2:0] basis1,
    input  logic signed [POSITION_BITS+2:0] basis2,
    input  logic signed [POSITION_BITS+2:0] basis3,
    input  logic signed [SAMPLE_BITS-1:0]   sample_start,
    input  logic signed [SAMPLE_BITS-1:0]   sample_end,
    input  logic signed [SAMPLE_BITS+6:0]   tan_start,
    input  logic signed [SAMPLE_BITS+6:0]   tan_end,
    output logic signed [SAMPLE_BITS-1:0]   value,
    output logic                            saturated
);

    localparam int S     = SAMPLE_BITS;
    localparam int P     = POSITION_BITS;
    localparam int A_W   = P + 3;
    localparam int M_W   = S + 7;
    localparam int PA_W  = A_W + S;
    localparam int PM_W  = A_W + M_W;
    localparam int ACC_W = PM_W + 2;
    localparam int V_W   = ACC_W - P;

    localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(1) << (P - 1);
    localparam logic signed [S-1:0]     VAL_HI   = {1'b0, {(S - 1){1'b1}}};
    localparam logic signed [S-1:0]     VAL_LO   = {1'b1, {(S - 1){1'b0}}};

    // Stage five: the four products.
    logic signed [PA_W-1:0] p0_reg, p3_reg;
    logic signed [PM_W-1:0] p1_reg, p2_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.load[4])
        begin
            p0_reg <= basis0 * sample_start;
            p1_reg <= basis1 * tan_start;
            p2_reg <= basis2 * tan_end;
            p3_reg <= basis3 * sample_end;
        end
    end

    // Stage six: accumulate, with the rounding half already added in.
    logic signed [ACC_W-1:0] acc_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.load[5])
        begin
            acc_reg <= ACC_W'(p0_reg) + ACC_W'(p1_reg) + ACC_W'(p2_reg)
                     + ACC_W'(p3_reg) + ACC_HALF;
        end
    end

    // Stage seven: drop the fraction and clip to the sample range.
    logic signed [V_W-1:0] v;
    logic [V_W-S:0]        upper;
    logic                  fits;
    logic signed [S-1:0]   value_reg;
    logic                  sat_reg;

    assign v     = acc_reg[ACC_W-1:P];
    assign upper = v[V_W-1:S-1];
    assign fits  = (&upper) || !(|upper);

    always_ff @(posedge clk)
    begin
        if (ctrl.load[6])
        begin
            value_reg <= fits ? v[S-1:0] : (v[V_W-1] ? VAL_LO : VAL_HI);
            sat_reg   <= !fits;
        end
    end

    assign value     = value_reg;
    assign saturated = sat_reg;

endmodule

@@ rtl/core/hermite_tension_bias_interpolator.sv @@
// Cubic Hermite interpolator with tension and bias weighting of the tangents.
// Pipeline: seven register stages from input transaction to result valid.
// Throughput: one transaction per cycle unless the output stalls; a stalled output holds
// only the stages behind it, and empty stages are filled while it waits.
// Reset clears all stage valid bits and returns tension and bias to zero.
module hermite_tension_bias_interpolator
#(
    parameter int SAMPLE_BITS   = hti_pkg::SAMPLE_BITS_DEF,
    parameter int POSITION_BITS = hti_pkg::POSITION_BITS_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 cfg_we,
    input  logic [hti_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [hti_pkg::REG_BITS-1:0]         cfg_data,

    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // sample_before, sample_start, sample_end, sample_after, position
    input  logic [((4*SAMPLE_BITS+POSITION_BITS+7)/8)*8-1:0] s_axis_tdata,

    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // value
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]     m_axis_tdata,
    // saturated
    output logic                                 m_axis_tuser
);

    localparam int S          = SAMPLE_BITS;
    localparam int P          = POSITION_BITS;
    localparam int A_W        = P + 3;
    localparam int M_W        = S + 7;
    localparam int OUT_DATA_W = ((S + 7) / 8) * 8;
    localparam int COEF_W     = hti_pkg::COEF_W;

    // Configuration: tension and bias are kept as their tangent weights.
    hti_pkg::coef_t coef_reg;
    hti_pkg::coef_t coef_next;

    always_comb
    begin
        coef_next = coef_reg;
        if (cfg_we)
        begin
            unique case (hti_pkg::cfg_reg_t'(cfg_index))
                hti_pkg::REG_TENSION:
                begin
                    coef_next.tension_minus = COEF_W'(hti_pkg::ONE_Q14)
                                            - COEF_W'($signed(cfg_data));
                end
                hti_pkg::REG_BIAS:
                begin
                    coef_next.bias_plus  = COEF_W'(hti_pkg::ONE_Q14)
                                         + COEF_W'($signed(cfg_data));
                    coef_next.bias_minus = COEF_W'(hti_pkg::ONE_Q14)
                                         - COEF_W'($signed(cfg_data));
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg.bias_plus     <= COEF_W'(hti_pkg::ONE_Q14);
            coef_reg.bias_minus    <= COEF_W'(hti_pkg::ONE_Q14);
            coef_reg.tension_minus <= COEF_W'(hti_pkg::ONE_Q14);
        end
        else
        begin
            coef_reg <= coef_next;
        end
    end

    // Stage control.
    hti_pkg::ctrl_t ctrl;

    hti_pipe_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .ctrl      (ctrl)
    );

    // Input field unpacking.
    logic signed [S-1:0] sample_before, sample_start, sample_end, sample_after;
    logic [P-1:0]        position;

    assign sample_before = s_axis_tdata[0*S +: S];
    assign sample_start  = s_axis_tdata[1*S +: S];
    assign sample_end    = s_axis_tdata[2*S +: S];
    assign sample_after  = s_axis_tdata[3*S +: S];
    assign position      = s_axis_tdata[4*S +: P];

    // Tangent and basis slices run side by side.
    logic signed [S-1:0]   start_d, end_d;
    logic signed [M_W-1:0] tan_start, tan_end;
    logic signed [A_W-1:0] basis0, basis1, basis2, basis3;

    hti_tangent #(.SAMPLE_BITS(S)) u_tangent
    (
        .clk           (clk),
        .ctrl          (ctrl),
        .coef          (coef_reg),
        .sample_before (sample_before),
        .sample_start  (sample_start),
        .sample_end    (sample_end),
        .sample_after  (sample_after),
        .start_out     (start_d),
        .end_out       (end_d),
        .tan_start     (tan_start),
        .tan_end       (tan_end)
    );

    hti_basis #(.POSITION_BITS(P)) u_basis
    (
        .clk      (clk),
        .ctrl     (ctrl),
        .position (position),
        .basis0   (basis0),
        .basis1   (basis1),
        .basis2   (basis2),
        .basis3   (basis3)
    );

    // Weighted sum and output register.
    logic signed [S-1:0] value;
    logic                saturated;

    hti_combine #(.SAMPLE_BITS(S), .POSITION_BITS(P)) u_combine
    (
        .clk          (clk),
        .ctrl         (ctrl),
        .basis0       (basis0),
        .basis1       (basis1),
        .basis2       (basis2),
        .basis3       (basis3),
        .sample_start (start_d),
        .sample_end   (end_d),
        .tan_start    (tan_start),
        .tan_end      (tan_end),
        .value        (value),
        .saturated    (saturated)
    );

    assign m_axis_tdata = OUT_DATA_W'($unsigned(value));
    assign m_axis_tuser = saturated;

    // With the output register empty every stage can move, so the input is open.
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while the output register is empty");

    // A clipped result sits at one of the two range limits.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |->
            (value == {1'b0, {(S - 1){1'b1}}} || value == {1'b1, {(S - 1){1'b0}}}))
        else $error("saturation flag set on a value inside the range");

    // A tension write lands as its tangent weight on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_we && hti_pkg::cfg_reg_t'(cfg_index) == hti_pkg::REG_TENSION) |=>
            (coef_reg.tension_minus == COEF_W'(hti_pkg::ONE_Q14)
                                     - COEF_W'($signed($past(cfg_data)))))
        else $error("tension weight does not follow the register write");

endmodule
